// ===== rtl/core/sswt_pkg.sv =====
package sswt_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int WINDOW_BITS_DEF = 64;

  typedef struct packed {
    logic [31:0] sender_key;
    logic [31:0] sequence_req;
  } in_word_t;

  typedef struct packed {
    logic        duplicate;
    logic [31:0] lost_count;
    logic        rolled_back;
    logic        new_sender;
  } out_word_t;

  typedef struct packed {
    logic duplicate;
    logic rolled_back;
    logic new_sender;
  } win_flags_t;

endpackage

// ===== rtl/core/sswt_ram.sv =====
module sswt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sswt_fold.sv =====
module sswt_fold #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              key,
  output logic                     done,
  output logic [$clog2(DEPTH)-1:0] idx
);

  localparam int AW = $clog2(DEPTH);
  localparam int SHIFT = 32 + AW;
  // floor(2^(32+AW) / DEPTH) + 1: exact quotient for any 32-bit dividend
  localparam logic [63:0] MAGIC64 = ((64'd1 << SHIFT) / DEPTH) + 64'd1;
  localparam logic [32:0] MAGIC = MAGIC64[32:0];
  localparam logic [31:0] DEPTH32 = 32'(DEPTH);
  localparam logic [6:0] GUARD_MAX = 7'd64;

  logic        busy_r, busy_nxt;
  logic        phase_r, phase_nxt;
  logic        done_r, done_nxt;
  logic [31:0] b_r, b_nxt;
  logic [6:0]  guard_r, guard_nxt;
  logic [64:0] prod_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0] quo, rem;
  logic [63:0] back;

  assign quo  = 32'(prod_r >> SHIFT);
  assign back = 64'(quo) * 64'(DEPTH32);
  assign rem  = b_r - back[31:0];

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    b_nxt     = b_r;
    guard_nxt = guard_r;
    idx_nxt   = idx_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      b_nxt     = key;
      guard_nxt = '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        phase_nxt = 1'b1;
      end else if ((b_r < DEPTH32) || (guard_r == GUARD_MAX)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        idx_nxt  = rem[AW-1:0];
      end else begin
        phase_nxt = 1'b0;
        b_nxt     = rem ^ quo;
        guard_nxt = guard_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    guard_r <= guard_nxt;
    idx_r   <= idx_nxt;
    prod_r  <= 65'(b_r) * 65'(MAGIC);
  end

  assign done = done_r;
  assign idx  = idx_r;

endmodule

// ===== rtl/core/sswt_window.sv =====
module sswt_window
  import sswt_pkg::*;
#(
  parameter int WINDOW_BITS = 64
) (
  input  logic                    clk,
  input  logic                    calc,
  input  logic [63+WINDOW_BITS:0] rd_entry,
  input  logic [31:0]             key,
  input  logic [31:0]             seq,
  output logic [63+WINDOW_BITS:0] wr_entry,
  output win_flags_t              flags,
  output logic [31:0]             lost_count
);

  localparam int W = WINDOW_BITS;
  localparam int WIDX = $clog2(W);
  localparam int PCW = $clog2(W + 1);
  localparam logic [33:0] W34 = 34'(W);
  localparam logic [31:0] W32 = 32'(W);
  localparam logic [32:0] W2_33 = 33'(2 * W);
  localparam logic [31:0] W2_32 = 32'(2 * W);
  localparam logic [WIDX:0] W_V = (WIDX + 1)'(W);
  localparam logic [W-1:0] ONE_W = W'(1);

  logic [31:0]  tag, head, d, sh, bitpos;
  logic [W-1:0] map, new_map, drop;
  logic [31:0]  new_head, extra;
  logic [33:0]  s34, h34;
  logic [WIDX-1:0] dlo;
  logic [WIDX:0] top_v;
  win_flags_t   fl;

  logic [W-1:0] drop_r;
  logic [31:0]  extra_r;
  win_flags_t   flags_r;
  logic [PCW-1:0] pc;
  logic [32:0]  lost_sum;

  assign tag  = rd_entry[63+W:32+W];
  assign head = rd_entry[31+W:W];
  assign map  = rd_entry[W-1:0];
  assign s34  = {2'b00, seq};
  assign h34  = {2'b00, head};
  assign d    = seq - head;
  assign sh   = head - seq - W32;
  assign bitpos = seq + W32 - head;
  assign dlo  = d[WIDX-1:0];
  assign top_v = W_V - {1'b0, dlo};

  always_comb begin
    new_map  = map;
    new_head = head;
    drop     = '0;
    extra    = '0;
    fl       = '0;
    if (tag != key) begin
      fl.new_sender = 1'b1;
      new_map       = '0;
      new_head      = seq;
    end else if (s34 + W34 < h34) begin
      fl.rolled_back = 1'b1;
      if ((s34 + W34 + W34 >= h34) && (sh < W32)) begin
        new_map = map << sh[WIDX-1:0];
      end else begin
        new_map = '0;
      end
      new_map[0] = 1'b1;
      new_head   = seq + W32;
    end else if (seq < head) begin
      fl.duplicate = map[bitpos[WIDX-1:0]];
      new_map[bitpos[WIDX-1:0]] = 1'b1;
    end else if (seq == head) begin
      fl.duplicate = (head != 32'd0);
    end else if (d < W32) begin
      if (head >= W32) begin
        drop = ~({W{1'b1}} << dlo) & ~map;
      end
      new_map  = (map >> dlo) | (ONE_W << top_v[WIDX-1:0]);
      new_head = seq;
    end else begin
      drop = ~map;
      if ({1'b0, d} >= W2_33) begin
        extra = d - W2_32;
      end
      new_map  = '0;
      new_head = seq;
    end
  end

  assign wr_entry = {key, new_head, new_map};

  always_ff @(posedge clk) begin
    if (calc) begin
      drop_r  <= drop;
      extra_r <= extra;
      flags_r <= fl;
    end
  end

  always_comb begin
    pc = '0;
    for (int i = 0; i < W; i++) begin
      pc = pc + PCW'(drop_r[i]);
    end
  end

  assign lost_sum   = {1'b0, extra_r} + 33'(pc);
  assign lost_count = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
  assign flags      = flags_r;

endmodule

// ===== rtl/core/sender_sequence_window_tracker.sv =====
// Flow: an accepted input word takes k key fold steps (1..65) to its table index,
// then a table read, an update step and an output step; no new word is taken until its
// result is loaded, and the iterative key fold and the single table read-modify-write
// per word set the rate (k is 1 to 4 at 1024 entries). Reset: synchronous, active low;
// afterwards the table is cleared one entry per cycle, with in_stall held high.
module sender_sequence_window_tracker
  import sswt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = 64 + WINDOW_BITS;
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CALC  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  in_word_t      in_word_r;
  out_word_t     out_word_r;

  logic          in_take, out_load;
  logic          fold_done;
  logic [AW-1:0] fold_idx;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata, win_entry;
  win_flags_t    win_flags;
  logic [31:0]   win_lost;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  sswt_fold #(
    .DEPTH(TABLE_DEPTH)
  ) u_fold (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_take),
    .key  (in_word.sender_key),
    .done (fold_done),
    .idx  (fold_idx)
  );

  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_CALC);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : fold_idx;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : win_entry;

  sswt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(fold_idx),
    .rdata(ram_rdata)
  );

  sswt_window #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .clk       (clk),
    .calc      (state_r == ST_CALC),
    .rd_entry  (ram_rdata),
    .key       (in_word_r.sender_key),
    .seq       (in_word_r.sequence_req),
    .wr_entry  (win_entry),
    .flags     (win_flags),
    .lost_count(win_lost)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (fold_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
    if (out_load) begin
      out_word_r.duplicate   <= win_flags.duplicate;
      out_word_r.lost_count  <= win_lost;
      out_word_r.rolled_back <= win_flags.rolled_back;
      out_word_r.new_sender  <= win_flags.new_sender;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result word appeared outside the output step");

  a_calc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |=> (state_r == ST_OUT))
    else $error("update step not followed by output step");

  a_fold_done_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
    fold_done |-> (state_r == ST_FOLD))
    else $error("key fold finished outside fold step");

  a_new_sender_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.new_sender) |->
      (!out_word_r.duplicate && !out_word_r.rolled_back && (out_word_r.lost_count == 32'd0)))
    else $error("new sender word carries window results");

  a_rollback_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.rolled_back) |->
      (!out_word_r.duplicate && (out_word_r.lost_count == 32'd0)))
    else $error("rollback word carries duplicate or loss");

endmodule
